// File: src/mtfhl_pkg.sv
// shared types and codes for the move-to-front handle list
// no dependencies
`timescale 1ns / 1ps

package mtfhl_pkg;

  // request selector codes (s_tuser)
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_RAISE = 2'd1;
  localparam logic [1:0] FUNC_LIST  = 2'd2;

  // result status codes (m_tuser)
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_NULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam int OUT_HANDLE_BITS = 32;
  localparam int OUT_POS_BITS    = 4;

  typedef struct packed {
    logic [2:0]                 status;
    logic [OUT_HANDLE_BITS-1:0] handle;
    logic [OUT_POS_BITS-1:0]    position;
    logic                       drawable;
    logic                       last;
  } res_t;

  function automatic res_t status_res(logic [2:0] st);
    res_t r;
    r          = '0;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

endpackage

// File: src/move_to_front_handle_list.sv
// Ordered handle list, front first, with push, raise-to-front and back-to-front
// listing. One request is worked at a time and s_tready stays low meanwhile.
// A push, a raise with a zero handle, a raise on an empty list and any list of an
// empty list finish in the cycle of the transfer. A raise scans the list through
// one comparator, one entry per cycle, to find its position k or to miss, then
// moves the k entries ahead of it back one place through the single ram port pair
// and writes it to the front. A list reads each entry through the registered ram
// read and waits on m_tready. Depends on mtfhl_pkg and mtfhl_ram.
`timescale 1ns / 1ps

module move_to_front_handle_list #(
  parameter int DEPTH       = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // handle[31:0], has_handler[32], zero pad
  input  logic [1:0]  s_tuser,  // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // out_handle[31:0], out_position[35:32], drawable[36], pad
  output logic [2:0]  m_tuser,  // status[2:0]
  output logic        m_tlast
);

  import mtfhl_pkg::*;

  localparam int SW = (HANDLE_BITS < OUT_HANDLE_BITS) ? HANDLE_BITS : OUT_HANDLE_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = SW + 1;

  typedef enum logic [2:0] {
    IDLE,
    SEARCH,
    SHIFT,
    FRONT,
    L_RD,
    L_LD
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic            pend;
  logic [AW-1:0]   pidx;
  logic [SW-1:0]   key;
  logic [RW-1:0]   tgt;
  res_t            res;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [RW-1:0]   ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [RW-1:0]   ram_rdata;

  logic            out_free;
  logic            in_xfer;
  logic [SW-1:0]   in_handle;
  logic            in_flag;
  logic            full;
  logic            hit;
  logic            at_end;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == IDLE) && out_free;
  assign in_xfer   = s_tvalid && s_tready;
  assign in_handle = s_tdata[SW-1:0];
  assign in_flag   = s_tdata[32];
  assign full      = (count == CW'(DEPTH));
  assign hit       = pend && (ram_rdata[SW-1:0] == key);
  assign at_end    = pend && ((CW'(pidx) + CW'(1)) == count);

  assign m_tdata = {3'b000, res.drawable, res.position, res.handle};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = {in_flag, in_handle};
    ram_re    = 1'b0;
    ram_raddr = ptr[AW-1:0];
    unique case (state)
      IDLE: begin
        ram_we = in_xfer && (s_tuser == FUNC_PUSH) && !full;
      end
      SEARCH: begin
        ram_re = (ptr < count);
      end
      SHIFT: begin
        // read the entry ahead while writing the one fetched last cycle
        ram_we    = pend;
        ram_waddr = pidx;
        ram_wdata = ram_rdata;
        ram_re    = (ptr != '0);
        ram_raddr = AW'(ptr - CW'(1));
      end
      FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = tgt;
      end
      L_RD: begin
        ram_re = 1'b1;
      end
      L_LD: begin
      end
      default: begin
      end
    endcase
  end

  mtfhl_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      ptr      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_xfer) begin
            case (s_tuser)
              FUNC_PUSH: begin
                m_tvalid <= 1'b1;
                if (full) begin
                  res <= status_res(ST_FULL);
                end else begin
                  res   <= status_res(ST_OK);
                  count <= count + CW'(1);
                end
              end
              FUNC_RAISE: begin
                if (in_handle == '0) begin
                  m_tvalid <= 1'b1;
                  res      <= status_res(ST_NULL);
                end else if (count == '0) begin
                  m_tvalid <= 1'b1;
                  res      <= status_res(ST_MISSING);
                end else begin
                  key   <= in_handle;
                  ptr   <= '0;
                  pend  <= 1'b0;
                  state <= SEARCH;
                end
              end
              FUNC_LIST: begin
                if (count == '0) begin
                  m_tvalid <= 1'b1;
                  res      <= status_res(ST_EMPTY);
                end else begin
                  ptr   <= count - CW'(1);
                  state <= L_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        SEARCH: begin
          if (hit) begin
            tgt <= ram_rdata;
            if (pidx == '0) begin
              m_tvalid <= 1'b1;
              res      <= status_res(ST_OK);
              state    <= IDLE;
            end else begin
              ptr   <= CW'(pidx);
              pend  <= 1'b0;
              state <= SHIFT;
            end
          end else if (at_end) begin
            m_tvalid <= 1'b1;
            res      <= status_res(ST_MISSING);
            state    <= IDLE;
          end else if (ptr < count) begin
            pend <= 1'b1;
            pidx <= ptr[AW-1:0];
            ptr  <= ptr + CW'(1);
          end else begin
            pend <= 1'b0;
          end
        end
        SHIFT: begin
          if (ptr != '0) begin
            pend <= 1'b1;
            pidx <= ptr[AW-1:0];
            ptr  <= ptr - CW'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= FRONT;
            end
          end
        end
        FRONT: begin
          m_tvalid <= 1'b1;
          res      <= status_res(ST_OK);
          state    <= IDLE;
        end
        L_RD: begin
          state <= L_LD;
        end
        L_LD: begin
          if (out_free) begin
            m_tvalid     <= 1'b1;
            res.status   <= ST_OK;
            res.handle   <= OUT_HANDLE_BITS'(ram_rdata[SW-1:0]);
            res.position <= OUT_POS_BITS'(ptr);
            res.drawable <= ram_rdata[SW];
            res.last     <= (ptr == '0);
            if (ptr == '0) begin
              state <= IDLE;
            end else begin
              ptr   <= ptr - CW'(1);
              state <= L_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // a raise in progress never has a result waiting
  a_raise_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == SEARCH || state == SHIFT || state == FRONT) |-> !m_tvalid)
    else $error("result pending during raise");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tuser == FUNC_PUSH && !full) |=> count == $past(count) + CW'(1))
    else $error("push did not grow the list");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    !(in_xfer && s_tuser == FUNC_PUSH) |=> $stable(count))
    else $error("entry count changed without a push");

  a_mid_list_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK))
    else $error("non-final result with error status");

endmodule

// File: src/mtfhl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mtfhl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
